### rtl/ssm_pkg.sv
`default_nettype none

package ssm_pkg;

  // Payload widths of the request and response transactions
  localparam int unsigned REQ_W = 3;
  localparam int unsigned KEY_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned ERR_W = 2;

  localparam int unsigned KEYS_DEFAULT = 1024;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_LOOKUP = 3'd2,
    REQ_LENGTH = 3'd3,
    REQ_GET    = 3'd4
  } req_type_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_KEY   = 2'd1,
    ERR_INDEX = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_RD1,
    ST_RD2
  } state_e;

endpackage

`default_nettype wire

### rtl/ssm_if.sv
`default_nettype none

interface ssm_req_if import ssm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value_in;
  logic [IDX_W-1:0] index;

  modport source (output valid, req_type, key, value_in, index, input ready);
  modport sink   (input valid, req_type, key, value_in, index, output ready);
endinterface

interface ssm_rsp_if import ssm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             present;
  logic [VAL_W-1:0] value_out;
  logic [CNT_W-1:0] count;
  logic [ERR_W-1:0] error;

  modport source (output valid, present, value_out, count, error, input ready);
  modport sink   (input valid, present, value_out, count, error, output ready);
endinterface

`default_nettype wire

### rtl/ssm_ram.sv
`default_nettype none

module ssm_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/ssm_ctrl.sv
`default_nettype none

module ssm_ctrl import ssm_pkg::*; #(
  parameter int unsigned Keys = KEYS_DEFAULT,
  localparam int unsigned AW = $clog2(Keys),
  localparam int unsigned SW = AW + VAL_W
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ssm_req_if.sink            req_i,
  ssm_rsp_if.source          rsp_o,
  // sparse store: {slot, value} per key
  output logic               sp_we_o,
  output logic [AW-1:0]      sp_waddr_o,
  output logic [SW-1:0]      sp_wdata_o,
  output logic               sp_re_o,
  output logic [AW-1:0]      sp_raddr_o,
  input  wire logic [SW-1:0] sp_rdata_i,
  // dense store: key per slot
  output logic               dn_we_o,
  output logic [AW-1:0]      dn_waddr_o,
  output logic [AW-1:0]      dn_wdata_o,
  output logic               dn_re_o,
  output logic [AW-1:0]      dn_raddr_o,
  input  wire logic [AW-1:0] dn_rdata_i
);

  localparam int unsigned CW = $clog2(Keys + 1);

  state_e st_q, st_d;

  logic [AW-1:0]    init_q;
  logic [CW-1:0]    cnt_q, cnt_d;

  // request held for the whole transaction
  logic [REQ_W-1:0] type_q;
  logic [AW-1:0]    key_q;
  logic             key_ok_q;
  logic [VAL_W-1:0] val_q;
  logic [IDX_W-1:0] idx_q;

  logic             fwd_sp_q;
  logic [SW-1:0]    fwd_sp_data_q;
  logic             fwd_dn_q;
  logic [AW-1:0]    fwd_dn_data_q;
  logic [SW-1:0]    sp_hold_q;

  logic             out_vld_q;
  logic             out_present_q;
  logic [VAL_W-1:0] out_value_q;
  logic [CNT_W-1:0] out_count_q;
  logic [ERR_W-1:0] out_error_q;

  logic             acc, adv, init_done;
  logic [31:0]      in_key_ext, in_idx_ext;
  logic [AW-1:0]    in_key_addr, in_idx_addr;
  logic             in_key_ok;
  logic [SW-1:0]    sp_word;
  logic [AW-1:0]    dn_word;
  logic [AW-1:0]    hold_slot;
  logic             member, idx_ok, room;
  logic             res_present;
  logic [VAL_W-1:0] res_value;
  err_e             res_error;
  logic [31:0]      cnt_ext;

  assign acc       = req_i.valid && req_i.ready;
  assign adv       = !out_vld_q || rsp_o.ready;
  assign init_done = (init_q == AW'(Keys - 1));

  assign req_i.ready = (st_q == ST_IDLE) || ((st_q == ST_RD2) && adv);

  assign in_key_ext  = 32'(req_i.key);
  assign in_idx_ext  = 32'(req_i.index);
  assign in_key_addr = in_key_ext[AW-1:0];
  assign in_idx_addr = in_idx_ext[AW-1:0];
  assign in_key_ok   = (in_key_ext < 32'(Keys));

  // Take the bypassed write data when the accept read hit the entry being written
  assign sp_word   = fwd_sp_q ? fwd_sp_data_q : sp_rdata_i;
  assign dn_word   = fwd_dn_q ? fwd_dn_data_q : dn_rdata_i;
  assign hold_slot = sp_hold_q[SW-1:VAL_W];

  assign member = key_ok_q && (CW'(hold_slot) < cnt_q) && (dn_rdata_i == key_q);
  assign idx_ok = (32'(idx_q) < 32'(cnt_q));
  assign room   = (cnt_q < CW'(Keys));

  // Decision in the second read cycle
  always_comb begin
    res_present = 1'b0;
    res_value   = '0;
    res_error   = ERR_NONE;
    cnt_d       = cnt_q;
    unique case (type_q)
      REQ_CLEAR: begin
        cnt_d = '0;
      end
      REQ_INSERT: begin
        if (!key_ok_q) begin
          res_error = ERR_KEY;
        end else if (member) begin
          res_present = 1'b1;
        end else if (room) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      REQ_LOOKUP: begin
        if (!key_ok_q) begin
          res_error = ERR_KEY;
        end else if (member) begin
          res_present = 1'b1;
          res_value   = sp_hold_q[VAL_W-1:0];
        end
      end
      REQ_GET: begin
        if (!idx_ok) begin
          res_error = ERR_INDEX;
        end else begin
          res_present = 1'b1;
          res_value   = sp_rdata_i[VAL_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_ext = 32'(cnt_d);

  // Next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_INIT: if (init_done) st_d = ST_IDLE;
      ST_IDLE: if (acc) st_d = ST_RD1;
      ST_RD1:  st_d = ST_RD2;
      ST_RD2: begin
        if (adv) begin
          st_d = acc ? ST_RD1 : ST_IDLE;
        end
      end
      default: st_d = ST_INIT;
    endcase
  end

  // Memory ports
  always_comb begin
    sp_we_o     = 1'b0;
    sp_waddr_o  = key_q;
    sp_wdata_o  = '0;
    sp_re_o     = 1'b0;
    sp_raddr_o  = in_key_addr;
    dn_we_o     = 1'b0;
    dn_waddr_o  = cnt_q[AW-1:0];
    dn_wdata_o  = key_q;
    dn_re_o     = 1'b0;
    dn_raddr_o  = in_idx_addr;

    if (acc) begin
      sp_re_o = 1'b1;
      dn_re_o = 1'b1;
    end

    unique case (st_q)
      ST_INIT: begin
        sp_we_o    = 1'b1;
        sp_waddr_o = init_q;
      end
      ST_RD1: begin
        if (type_q == REQ_GET) begin
          sp_re_o    = 1'b1;
          sp_raddr_o = dn_word;
        end else begin
          dn_re_o    = 1'b1;
          dn_raddr_o = sp_word[SW-1:VAL_W];
        end
      end
      ST_RD2: begin
        if (adv && (type_q == REQ_INSERT) && key_ok_q) begin
          if (member) begin
            sp_we_o    = 1'b1;
            sp_wdata_o = {hold_slot, val_q};
          end else if (room) begin
            sp_we_o    = 1'b1;
            sp_wdata_o = {cnt_q[AW-1:0], val_q};
            dn_we_o    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_INIT;
      init_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      fwd_sp_q  <= 1'b0;
      fwd_dn_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_INIT && !init_done) begin
        init_q <= init_q + 1'b1;
      end
      if (st_q == ST_RD2 && adv) begin
        cnt_q     <= cnt_d;
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (acc) begin
        fwd_sp_q <= sp_we_o && (sp_waddr_o == in_key_addr);
        fwd_dn_q <= dn_we_o && (dn_waddr_o == in_idx_addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      type_q        <= req_i.req_type;
      key_q         <= in_key_addr;
      key_ok_q      <= in_key_ok;
      val_q         <= req_i.value_in;
      idx_q         <= req_i.index;
      fwd_sp_data_q <= sp_wdata_o;
      fwd_dn_data_q <= dn_wdata_o;
    end
    if (st_q == ST_RD1) begin
      sp_hold_q <= sp_word;
    end
    if (st_q == ST_RD2 && adv) begin
      out_present_q <= res_present;
      out_value_q   <= res_value;
      out_count_q   <= cnt_ext[CNT_W-1:0];
      out_error_q   <= res_error;
    end
  end

  assign rsp_o.valid     = out_vld_q;
  assign rsp_o.present   = out_present_q;
  assign rsp_o.value_out = out_value_q;
  assign rsp_o.count     = out_count_q;
  assign rsp_o.error     = out_error_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Keys))
    else $error("member count above capacity");

  a_acc_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> (st_q == ST_IDLE || st_q == ST_RD2))
    else $error("request taken while a transaction is in flight");

  a_append_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dn_we_o |=> (cnt_q == CW'($past(cnt_q) + 1'b1)))
    else $error("dense append without count increment");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RD2 && out_vld_q && !rsp_o.ready) |=> (st_q == ST_RD2))
    else $error("result dropped while output stalled");

  a_no_wr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RD2 && !adv) |-> (!sp_we_o && !dn_we_o))
    else $error("store written while result is held");

endmodule

`default_nettype wire

### rtl/sparse_set_map_unit.sv
// Sparse-set map over keys 0..Keys-1 with constant-time clear.
// Channels: req_i carries one request per transaction (req_type, key,
// value_in, index); rsp_o returns exactly one response per request
// (present, value_out, count, error), in request order. Both use
// valid/ready; a transaction completes when both are high at a clock edge.
// State lives in two single-port-read RAMs with registered read data:
// a key-indexed store of {slot, value} and a slot-indexed store of keys.
// Flow: an accepted request reads both stores, then a dependent second
// read follows (slot store for key requests, key store for GET), and the
// response is registered. A new request waits while one is in its reads;
// the next request is accepted in the cycle the previous one finishes and
// writes back, with bypass on the same entry.
// Reset: the member count clears, then the key store is swept one entry per
// cycle over all Keys entries, with req_i.ready low during the sweep.
// Stall: when rsp_o is not taken, the finished response waits in the output
// register; the block then holds the next request in its second read
// cycle and performs no write until the output frees up.
`default_nettype none

module sparse_set_map_unit import ssm_pkg::*; #(
  parameter int unsigned Keys = KEYS_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssm_req_if.sink   req_i,
  ssm_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(Keys);
  localparam int unsigned SW = AW + VAL_W;

  logic          sp_we, sp_re, dn_we, dn_re;
  logic [AW-1:0] sp_waddr, sp_raddr, dn_waddr, dn_raddr;
  logic [SW-1:0] sp_wdata, sp_rdata;
  logic [AW-1:0] dn_wdata, dn_rdata;

  ssm_ctrl #(
    .Keys(Keys)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .sp_we_o   (sp_we),
    .sp_waddr_o(sp_waddr),
    .sp_wdata_o(sp_wdata),
    .sp_re_o   (sp_re),
    .sp_raddr_o(sp_raddr),
    .sp_rdata_i(sp_rdata),
    .dn_we_o   (dn_we),
    .dn_waddr_o(dn_waddr),
    .dn_wdata_o(dn_wdata),
    .dn_re_o   (dn_re),
    .dn_raddr_o(dn_raddr),
    .dn_rdata_i(dn_rdata)
  );

  ssm_ram #(
    .Depth(Keys),
    .Width(SW)
  ) u_sparse_ram (
    .clk_i  (clk_i),
    .we_i   (sp_we),
    .waddr_i(sp_waddr),
    .wdata_i(sp_wdata),
    .re_i   (sp_re),
    .raddr_i(sp_raddr),
    .rdata_o(sp_rdata)
  );

  ssm_ram #(
    .Depth(Keys),
    .Width(AW)
  ) u_dense_ram (
    .clk_i  (clk_i),
    .we_i   (dn_we),
    .waddr_i(dn_waddr),
    .wdata_i(dn_wdata),
    .re_i   (dn_re),
    .raddr_i(dn_raddr),
    .rdata_o(dn_rdata)
  );

endmodule

`default_nettype wire

### tb/sparse_set_map_unit_test.sv
`default_nettype none

module sparse_set_map_unit_test;
  import ssm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KEYS         = KEYS_DEFAULT;
  localparam time         CLK_PERIOD   = 12ns;
  localparam int unsigned ITEMS        = 1650;
  localparam int unsigned IDLE_PCT     = 26;
  localparam int unsigned CALM_FROM    = 400;
  localparam int unsigned CALM_TO      = 700;
  localparam int unsigned DRAIN_CYCLES = 16;
  // reset sweep writes all KEYS entries with ready low, so leave ample room
  localparam int unsigned STUCK_LIMIT  = 5000;

  // request codes outside the defined set; the block must answer them harmlessly
  localparam logic [REQ_W-1:0] REQ_SPARE5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0] op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } map_req_t;

  typedef struct packed {
    logic             present;
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic [ERR_W-1:0] error;
  } map_rsp_t;

  typedef struct packed {
    map_req_t rq;
    bit       typed;
    map_rsp_t rs;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ssm_req_if req_if ();
  ssm_rsp_if rsp_if ();

  sparse_set_map_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // shadow copy of the map
  bit [KEY_W-1:0] slot_of    [KEYS];
  bit [KEY_W-1:0] dense_key  [KEYS];
  bit [VAL_W-1:0] stored_val [KEYS];
  bit [CNT_W-1:0] members;

  map_rsp_t    pending_rsp [$];
  int unsigned sent;
  int unsigned checked;
  int unsigned mismatches;
  int unsigned stuck_cycles;
  int unsigned hits;
  int unsigned index_errs;
  int unsigned peak_members;
  bit          no_stall;

  function automatic bit holds_key(logic [KEY_W-1:0] k);
    if (k >= KEYS) return 1'b0;
    if (slot_of[k] >= members) return 1'b0;
    return dense_key[slot_of[k]] == k;
  endfunction

  function automatic map_rsp_t predict_map(map_req_t rq);
    map_rsp_t r;
    r = '0;
    case (rq.op)
      REQ_CLEAR: members = '0;
      REQ_INSERT: begin
        if (rq.key >= KEYS) begin
          r.error = ERR_KEY;
        end else if (holds_key(rq.key)) begin
          r.present = 1'b1;
          stored_val[rq.key] = rq.value;
        end else if (members < KEYS) begin
          dense_key[members[KEY_W-1:0]] = rq.key;
          slot_of[rq.key] = members[KEY_W-1:0];
          stored_val[rq.key] = rq.value;
          members++;
        end
      end
      REQ_LOOKUP: begin
        if (rq.key >= KEYS) begin
          r.error = ERR_KEY;
        end else if (holds_key(rq.key)) begin
          r.present = 1'b1;
          r.value = stored_val[rq.key];
        end
      end
      REQ_GET: begin
        if (rq.index >= members) begin
          r.error = ERR_INDEX;
        end else begin
          r.present = 1'b1;
          r.value = stored_val[dense_key[rq.index]];
        end
      end
      default: ;
    endcase
    r.count = members;
    if (members > peak_members) peak_members = members;
    if (r.present) hits++;
    if (r.error == ERR_INDEX) index_errs++;
    return r;
  endfunction

  function automatic map_req_t req_of(logic [REQ_W-1:0] op, logic [KEY_W-1:0] k,
                                      logic [VAL_W-1:0] v, logic [IDX_W-1:0] ix);
    map_req_t rq;
    rq.op = op;
    rq.key = k;
    rq.value = v;
    rq.index = ix;
    return rq;
  endfunction

  function automatic stim_row_t stim_row(logic [REQ_W-1:0] op, logic [KEY_W-1:0] k,
                                         logic [VAL_W-1:0] v, logic [IDX_W-1:0] ix,
                                         bit typed, logic p, logic [VAL_W-1:0] ev,
                                         logic [CNT_W-1:0] ec, logic [ERR_W-1:0] ee);
    stim_row_t row;
    row.rq = req_of(op, k, v, ix);
    row.typed = typed;
    row.rs.present = p;
    row.rs.value = ev;
    row.rs.count = ec;
    row.rs.error = ee;
    return row;
  endfunction

  // Drive one request and hold it until the transaction completes.
  task automatic send(map_req_t rq, bit typed, map_rsp_t typed_rsp);
    map_rsp_t predicted;
    while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= rq.op;
    req_if.key      <= rq.key;
    req_if.value_in <= rq.value;
    req_if.index    <= rq.index;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = predict_map(rq);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    sent++;
    no_stall <= (sent >= CALM_FROM) && (sent < CALM_TO);
  endtask

  // Hold off the sender until every outstanding response is back.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned n);
    int unsigned span;
    int unsigned base;
    int unsigned r;
    int unsigned ix_hi;
    map_req_t    rq;
    r = $urandom_range(99);
    span = (r < 70) ? $urandom_range(2, 24) : (r < 90) ? $urandom_range(25, 200) : KEYS;
    base = $urandom_range(0, KEYS - span);
    repeat (n) begin
      // unused fields carry random junk
      rq = req_of(REQ_LENGTH, KEY_W'($urandom), $urandom, IDX_W'($urandom));
      r = $urandom_range(99);
      if (r < 38) begin
        rq.op = REQ_INSERT;
        rq.key = KEY_W'(base + $urandom_range(0, span - 1));
        if ($urandom_range(9) == 0) rq.value = $urandom_range(1) ? '1 : '0;
      end else if (r < 68) begin
        rq.op = REQ_LOOKUP;
        if ($urandom_range(9) != 0) rq.key = KEY_W'(base + $urandom_range(0, span - 1));
      end else if (r < 83) begin
        rq.op = REQ_GET;
        ix_hi = (members < KEYS) ? members : KEYS - 1;
        if ($urandom_range(4) != 0) rq.index = IDX_W'($urandom_range(0, ix_hi));
      end else if (r < 88) begin
        rq.op = REQ_LENGTH;
      end else if (r < 91) begin
        rq.op = REQ_CLEAR;
      end else begin
        case ($urandom_range(2))
          0:       rq.op = REQ_SPARE5;
          1:       rq.op = REQ_SPARE6;
          default: rq.op = REQ_SPARE7;
        endcase
      end
      send(rq, 1'b0, '0);
    end
  endtask

  // Clear, then fill the set with every key in shuffled order, probing along the way.
  task automatic fill_phase();
    int unsigned perm [KEYS];
    int unsigned j;
    int unsigned tmp;
    map_req_t    rq;
    for (int i = 0; i < KEYS; i++) perm[i] = i;
    for (int i = KEYS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    send(req_of(REQ_CLEAR, KEY_W'($urandom), $urandom, IDX_W'($urandom)), 1'b0, '0);
    for (int i = 0; i < KEYS; i++) begin
      send(req_of(REQ_INSERT, KEY_W'(perm[i]), $urandom, IDX_W'($urandom)), 1'b0, '0);
      if ($urandom_range(99) < 12) begin
        if ($urandom_range(1) != 0) begin
          rq = req_of(REQ_LOOKUP, KEY_W'($urandom), $urandom, IDX_W'($urandom));
        end else begin
          rq = req_of(REQ_GET, KEY_W'($urandom), $urandom,
                      IDX_W'($urandom_range(0, i + 1)));
        end
        send(rq, 1'b0, '0);
      end
    end
    // full set: top index valid, update of an existing key keeps the count
    send(req_of(REQ_GET, KEY_W'($urandom), $urandom, IDX_W'(KEYS - 1)), 1'b0, '0);
    send(req_of(REQ_GET, KEY_W'($urandom), $urandom, '0), 1'b0, '0);
    send(req_of(REQ_LOOKUP, KEY_W'($urandom), $urandom, IDX_W'($urandom)), 1'b0, '0);
    send(req_of(REQ_INSERT, KEY_W'($urandom), $urandom, IDX_W'($urandom)), 1'b0, '0);
    send(req_of(REQ_LENGTH, KEY_W'($urandom), $urandom, IDX_W'($urandom)), 1'b0, '0);
    send(req_of(REQ_CLEAR, KEY_W'($urandom), $urandom, IDX_W'($urandom)), 1'b0, '0);
  endtask

  // Response sink: random back-pressure except in the calm stretch.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void check_field(string name, logic [VAL_W-1:0] exp_v,
                                      logic [VAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    map_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected response: expected none, actual count %0d", $time,
                 rsp_if.count);
      end else begin
        want = pending_rsp.pop_front();
        checked++;
        check_field("present", VAL_W'(want.present), VAL_W'(rsp_if.present));
        check_field("value_out", want.value, rsp_if.value_out);
        check_field("count", VAL_W'(want.count), VAL_W'(rsp_if.count));
        check_field("error", VAL_W'(want.error), VAL_W'(rsp_if.error));
      end
    end
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d responses outstanding", $time,
               STUCK_LIMIT, pending_rsp.size());
      $display("sparse_set_map_unit verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t directed [$];

    req_if.valid    = 1'b0;
    req_if.req_type = REQ_LENGTH;
    req_if.key      = '0;
    req_if.value_in = '0;
    req_if.index    = '0;

    // empty map after reset
    directed.push_back(stim_row(REQ_LENGTH, '0, '0, '0, 1, 0, '0, 0, ERR_NONE));
    directed.push_back(stim_row(REQ_LOOKUP, '0, '0, '0, 1, 0, '0, 0, ERR_NONE));
    directed.push_back(stim_row(REQ_LOOKUP, '1, '1, '1, 1, 0, '0, 0, ERR_NONE));
    directed.push_back(stim_row(REQ_GET, '0, '0, '0, 1, 0, '0, 0, ERR_INDEX));
    directed.push_back(stim_row(REQ_GET, '1, '1, '1, 1, 0, '0, 0, ERR_INDEX));
    // extreme keys and values
    directed.push_back(stim_row(REQ_INSERT, '0, '1, '0, 1, 0, '0, 1, ERR_NONE));
    directed.push_back(stim_row(REQ_INSERT, '1, '0, '1, 1, 0, '0, 2, ERR_NONE));
    directed.push_back(stim_row(REQ_INSERT, 10'h2aa, 32'ha5a5a5a5, 10'h155,
                                1, 0, '0, 3, ERR_NONE));
    directed.push_back(stim_row(REQ_LOOKUP, '0, '0, '0, 1, 1, '1, 3, ERR_NONE));
    directed.push_back(stim_row(REQ_LOOKUP, '1, '0, '0, 1, 1, '0, 3, ERR_NONE));
    // insert of a present key only updates its value
    directed.push_back(stim_row(REQ_INSERT, '0, 32'h12345678, '0, 1, 1, '0, 3, ERR_NONE));
    directed.push_back(stim_row(REQ_LOOKUP, '0, '0, '0, 1, 1, 32'h12345678, 3, ERR_NONE));
    directed.push_back(stim_row(REQ_GET, '1, '0, 10'd0, 1, 1, 32'h12345678, 3, ERR_NONE));
    directed.push_back(stim_row(REQ_GET, '0, '0, 10'd2, 1, 1, 32'ha5a5a5a5, 3, ERR_NONE));
    directed.push_back(stim_row(REQ_GET, '0, '0, 10'd3, 1, 0, '0, 3, ERR_INDEX));
    // undefined request codes change nothing
    directed.push_back(stim_row(REQ_SPARE5, 10'h155, 32'h5a5a5a5a, '1, 1, 0, '0, 3, ERR_NONE));
    directed.push_back(stim_row(REQ_SPARE6, '1, '1, '0, 1, 0, '0, 3, ERR_NONE));
    directed.push_back(stim_row(REQ_SPARE7, '0, '0, '1, 1, 0, '0, 3, ERR_NONE));
    directed.push_back(stim_row(REQ_LENGTH, '1, '1, '1, 1, 0, '0, 3, ERR_NONE));
    // clear, then stale slots must not alias
    directed.push_back(stim_row(REQ_CLEAR, '1, '1, '1, 1, 0, '0, 0, ERR_NONE));
    directed.push_back(stim_row(REQ_GET, '0, '0, '0, 1, 0, '0, 0, ERR_INDEX));
    directed.push_back(stim_row(REQ_INSERT, 10'h155, 32'h5a5a5a5a, '0, 1, 0, '0, 1, ERR_NONE));
    directed.push_back(stim_row(REQ_LOOKUP, '0, '0, '0, 1, 0, '0, 1, ERR_NONE));
    directed.push_back(stim_row(REQ_LOOKUP, 10'h2aa, '0, '0, 1, 0, '0, 1, ERR_NONE));
    directed.push_back(stim_row(REQ_INSERT, '0, 32'hdeadbeef, '0, 0, 0, '0, 0, ERR_NONE));
    directed.push_back(stim_row(REQ_GET, '0, '0, 10'd1, 0, 0, '0, 0, ERR_NONE));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send(directed[i].rq, directed[i].typed, directed[i].rs);
    settle();

    while (sent < 300) begin
      run_phase($urandom_range(20, 60));
      if ($urandom_range(2) == 0) settle();
    end
    fill_phase();
    settle();
    while (sent < ITEMS) begin
      run_phase($urandom_range(20, 80));
      if ($urandom_range(2) == 0) settle();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests issued, %0d responses checked, %0d hits, %0d index errors",
             sent, checked, hits, index_errs);
    $display("peak membership %0d of %0d keys, including a full-set fill and clear",
             peak_members, KEYS);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("sparse_set_map_unit verification clean");
    end else begin
      if (pending_rsp.size() != 0) begin
        $display("%0t: %0d expected responses never arrived", $time, pending_rsp.size());
      end
      $display("sparse_set_map_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
